// ===== sv/tomux_pkg.sv =====
// Shared constants, types and helper functions of the timestamp ordered packet muxer.
`timescale 1ns / 1ps
`default_nettype none

package tomux_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Input operation codes
   localparam logic [1:0] OP_FRAME  = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;

   // Packet channel codes
   localparam logic [1:0] CH_VIDEO = 2'd0;
   localparam logic [1:0] CH_AUDIO = 2'd1;
   localparam logic [1:0] CH_DUMMY = 2'd3;

   // Fixed length codes of audio and dummy packets
   localparam logic [39:0] CODE_AUDIO = 40'h04;
   localparam logic [39:0] CODE_DUMMY = 40'h00;
   localparam logic [2:0]  CODE_ONE_BYTE = 3'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_PICK,
      ST_EMIT,
      ST_DUMMY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic push;
      logic read;
      logic pick;
      logic emit;
      logic emit_dummy;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drain;
      logic known_op;
      logic frame_ready;
      logic sample_ready;
      logic dummy_ok;
      logic out_free;
   } status_type;

   // Big-endian 7-bit varint, right aligned; every byte but the final one has bit 7 set.
   function automatic logic [39:0] varint_code(input logic [31:0] len);
      logic [39:0] code;
      code       = '0;
      code[6:0]  = len[6:0];
      if (len[31:7] != '0) begin
         code[15:8] = {1'b1, len[13:7]};
      end
      if (len[31:14] != '0) begin
         code[23:16] = {1'b1, len[20:14]};
      end
      if (len[31:21] != '0) begin
         code[31:24] = {1'b1, len[27:21]};
      end
      if (len[31:28] != '0) begin
         code[39:32] = {1'b1, 3'b000, len[31:28]};
      end
      return code;
   endfunction

   function automatic logic [2:0] varint_bytes(input logic [31:0] len);
      logic [2:0] n;
      if (len[31:28] != '0) begin
         n = 3'd5;
      end else if (len[27:21] != '0) begin
         n = 3'd4;
      end else if (len[20:14] != '0) begin
         n = 3'd3;
      end else if (len[13:7] != '0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tomux_ctrl.sv =====
// Sequencing state machine of the timestamp ordered packet muxer.
`timescale 1ns / 1ps
`default_nettype none

module tomux_ctrl
   import tomux_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.known_op ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            if (status.drain) begin
               if (status.frame_ready || status.sample_ready) begin
                  cmd.read = 1'b1;
                  state_in = ST_PICK;
               end else if (status.dummy_ok) begin
                  state_in = ST_DUMMY;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (status.frame_ready && status.sample_ready) begin
               cmd.read = 1'b1;
               state_in = ST_PICK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DUMMY: begin
            if (status.out_free) begin
               cmd.emit_dummy = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/tomux_dp.sv =====
// Queues, pointers, timestamp state and result register of the packet muxer.
`timescale 1ns / 1ps
`default_nettype none

module tomux_dp
   import tomux_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  wire         [1:0]  req_op,
   input  wire         [63:0] req_stamp,
   input  wire         [31:0] req_frame_length,
   input  wire signed  [15:0] req_left_in,
   input  wire signed  [15:0] req_right_in,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [1:0]  rsp_channel,
   output logic        [31:0] rsp_time_delta,
   output logic               rsp_subtype,
   output logic        [39:0] rsp_length_code,
   output logic        [2:0]  rsp_length_code_bytes,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic               rsp_overflow_seen,
   output logic               rsp_last
);

   // Queue storage
   logic [63:0] frame_stamp_mem  [QUEUE_DEPTH];
   logic [31:0] frame_length_mem [QUEUE_DEPTH];
   logic [63:0] sample_stamp_mem [QUEUE_DEPTH];
   logic [31:0] sample_value_mem [QUEUE_DEPTH];

   // Captured input item
   logic [1:0]  op_ff;
   logic [63:0] stamp_ff;
   logic [31:0] length_ff;
   logic [31:0] value_ff;

   // Queue control
   logic [PTR_W-1:0] frame_head_ff,  frame_head_in;
   logic [PTR_W-1:0] sample_head_ff, sample_head_in;
   logic [CNT_W-1:0] frame_count_ff, frame_count_in;
   logic [CNT_W-1:0] sample_count_ff, sample_count_in;
   logic [63:0]      last_stamp_ff, last_stamp_in;
   logic             overflow_ff, overflow_in;

   // Head read data and ordering choice
   logic [63:0] frame_stamp_rd_ff;
   logic [31:0] frame_length_rd_ff;
   logic [63:0] sample_stamp_rd_ff;
   logic [31:0] sample_value_rd_ff;
   logic        pick_frame_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  channel_ff;
   logic [31:0] delta_ff;
   logic        subtype_ff;
   logic [39:0] code_ff;
   logic [2:0]  code_bytes_ff;
   logic [31:0] lr_ff;
   logic        overflow_seen_ff;
   logic        last_ff;

   logic [PTR_W-1:0] frame_tail;
   logic [PTR_W-1:0] sample_tail;
   logic             frame_full;
   logic             sample_full;
   logic             out_free;
   logic             pick_frame_in;
   logic [63:0]      emit_stamp;
   logic [CNT_W-1:0] frame_after;
   logic [CNT_W-1:0] sample_after;
   logic             more;
   logic             do_push_frame;
   logic             do_push_sample;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign frame_tail     = wrap_add(frame_head_ff, frame_count_ff);
   assign sample_tail    = wrap_add(sample_head_ff, sample_count_ff);
   assign frame_full     = (frame_count_ff == CNT_FULL);
   assign sample_full    = (sample_count_ff == CNT_FULL);
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign do_push_frame  = cmd.push && (op_ff == OP_FRAME) && !frame_full;
   assign do_push_sample = cmd.push && (op_ff == OP_SAMPLE) && !sample_full;

   assign status.drain        = (op_ff == OP_END);
   assign status.known_op     = (op_ff == OP_FRAME) || (op_ff == OP_SAMPLE)
                                || (op_ff == OP_END);
   assign status.frame_ready  = (frame_count_ff != '0);
   assign status.sample_ready = (sample_count_ff != '0);
   assign status.dummy_ok     = (last_stamp_ff <= stamp_ff);
   assign status.out_free     = out_free;

   // Frame wins a tie; a lone non-empty queue wins outright while draining.
   assign pick_frame_in = status.frame_ready &&
                          (!status.sample_ready || (frame_stamp_rd_ff <= sample_stamp_rd_ff));

   assign emit_stamp   = pick_frame_ff ? frame_stamp_rd_ff : sample_stamp_rd_ff;
   assign frame_after  = frame_count_ff - CNT_W'(pick_frame_ff);
   assign sample_after = sample_count_ff - CNT_W'(!pick_frame_ff);

   always_comb begin
      if (status.drain) begin
         more = (frame_after != '0) || (sample_after != '0) || (emit_stamp <= stamp_ff);
      end else begin
         more = (frame_after != '0) && (sample_after != '0);
      end
   end

   // Memories
   always_ff @(posedge clock) begin
      if (do_push_frame) begin
         frame_stamp_mem[frame_tail]  <= stamp_ff;
         frame_length_mem[frame_tail] <= length_ff;
      end
      if (do_push_sample) begin
         sample_stamp_mem[sample_tail] <= stamp_ff;
         sample_value_mem[sample_tail] <= value_ff;
      end
      if (cmd.read) begin
         frame_stamp_rd_ff  <= frame_stamp_mem[frame_head_ff];
         frame_length_rd_ff <= frame_length_mem[frame_head_ff];
         sample_stamp_rd_ff <= sample_stamp_mem[sample_head_ff];
         sample_value_rd_ff <= sample_value_mem[sample_head_ff];
      end
   end

   // Next state of the queue control and timestamp state
   always_comb begin
      frame_head_in   = frame_head_ff;
      sample_head_in  = sample_head_ff;
      frame_count_in  = frame_count_ff;
      sample_count_in = sample_count_ff;
      last_stamp_in   = last_stamp_ff;
      overflow_in     = overflow_ff;
      if (cmd.push) begin
         if (do_push_frame) begin
            frame_count_in = frame_count_ff + CNT_W'(1);
         end
         if (do_push_sample) begin
            sample_count_in = sample_count_ff + CNT_W'(1);
         end
         if (((op_ff == OP_FRAME) && frame_full) || ((op_ff == OP_SAMPLE) && sample_full)) begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         last_stamp_in = emit_stamp;
         if (pick_frame_ff) begin
            frame_head_in  = wrap_inc(frame_head_ff);
            frame_count_in = frame_after;
         end else begin
            sample_head_in  = wrap_inc(sample_head_ff);
            sample_count_in = sample_after;
         end
      end
      if (cmd.emit_dummy) begin
         last_stamp_in = stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_head_ff   <= '0;
         sample_head_ff  <= '0;
         frame_count_ff  <= '0;
         sample_count_ff <= '0;
         last_stamp_ff   <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_head_ff   <= frame_head_in;
         sample_head_ff  <= sample_head_in;
         frame_count_ff  <= frame_count_in;
         sample_count_ff <= sample_count_in;
         last_stamp_ff   <= last_stamp_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = (cmd.emit || cmd.emit_dummy) || (rsp_valid_ff && rsp_stall);

   // Captured item, ordering choice and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         stamp_ff  <= req_stamp;
         length_ff <= req_frame_length;
         value_ff  <= {req_left_in, req_right_in};
      end
      if (cmd.pick) begin
         pick_frame_ff <= pick_frame_in;
      end
      if (cmd.emit) begin
         channel_ff       <= pick_frame_ff ? CH_VIDEO : CH_AUDIO;
         delta_ff         <= emit_stamp[31:0] - last_stamp_ff[31:0];
         subtype_ff       <= 1'b1;
         code_ff          <= pick_frame_ff ? varint_code(frame_length_rd_ff) : CODE_AUDIO;
         code_bytes_ff    <= pick_frame_ff ? varint_bytes(frame_length_rd_ff) : CODE_ONE_BYTE;
         lr_ff            <= pick_frame_ff ? 32'd0 : sample_value_rd_ff;
         overflow_seen_ff <= overflow_ff;
         last_ff          <= !more;
      end else if (cmd.emit_dummy) begin
         channel_ff       <= CH_DUMMY;
         delta_ff         <= stamp_ff[31:0] - last_stamp_ff[31:0];
         subtype_ff       <= 1'b0;
         code_ff          <= CODE_DUMMY;
         code_bytes_ff    <= CODE_ONE_BYTE;
         lr_ff            <= 32'd0;
         overflow_seen_ff <= overflow_ff;
         last_ff          <= 1'b1;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel           = channel_ff;
   assign rsp_time_delta        = delta_ff;
   assign rsp_subtype           = subtype_ff;
   assign rsp_length_code       = code_ff;
   assign rsp_length_code_bytes = code_bytes_ff;
   assign rsp_left_out          = signed'(lr_ff[31:16]);
   assign rsp_right_out         = signed'(lr_ff[15:0]);
   assign rsp_overflow_seen     = overflow_seen_ff;
   assign rsp_last              = last_ff;

endmodule

`default_nettype wire

// ===== sv/timestamp_ordered_packet_muxer_unit.sv =====
// Top level of the timestamp ordered packet muxer: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// The muxer takes video frame descriptors and stereo audio samples, queues each
// kind in a queue of QUEUE_DEPTH entries, and emits packet headers in timestamp
// order: whenever both queues hold entries, the head with the earlier timestamp
// leaves first and a frame wins a tie. An end-of-stream transfer drains both
// queues in the same order and then emits a dummy packet when its timestamp is
// not below the last one written. Each packet carries the 32-bit wrapping delta
// from the previous packet's timestamp, and the last packet caused by an input
// transfer is marked. A push to a full queue is dropped and sets a sticky flag
// that every following packet reports. Items are handled one at a time: an
// input transfer passes through capture, push and a check of the queue heads
// (an unused operation code skips the check), and every packet adds a head
// read from the queue memories with a registered read port, a 64-bit
// timestamp comparison and the result write, while a dummy packet adds its
// own write step; a stalled result side lengthens the packet step until the
// result register is free. The result register lets a new input transfer be
// taken while the previous packet still waits.

module timestamp_ordered_packet_muxer_unit
   import tomux_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_op,
   input  wire         [63:0] req_stamp,
   input  wire         [31:0] req_frame_length,
   input  wire signed  [15:0] req_left_in,
   input  wire signed  [15:0] req_right_in,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [1:0]  rsp_channel,
   output logic        [31:0] rsp_time_delta,
   output logic               rsp_subtype,
   output logic        [39:0] rsp_length_code,
   output logic        [2:0]  rsp_length_code_bytes,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic               rsp_overflow_seen,
   output logic               rsp_last
);

   // Commands flow from the controller to the datapath; status flows back.
   cmd_type    cmd;
   status_type status;

   // The controller decides when to capture, push, read the queue heads,
   // choose the earlier head and send a packet to the result register.
   tomux_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the queues, the last written timestamp, the overflow
   // flag and the result register that drives the response channel.
   tomux_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_op                (req_op),
      .req_stamp             (req_stamp),
      .req_frame_length      (req_frame_length),
      .req_left_in           (req_left_in),
      .req_right_in          (req_right_in),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_channel           (rsp_channel),
      .rsp_time_delta        (rsp_time_delta),
      .rsp_subtype           (rsp_subtype),
      .rsp_length_code       (rsp_length_code),
      .rsp_length_code_bytes (rsp_length_code_bytes),
      .rsp_left_out          (rsp_left_out),
      .rsp_right_out         (rsp_right_out),
      .rsp_overflow_seen     (rsp_overflow_seen),
      .rsp_last              (rsp_last)
   );

`ifndef SYNTHESIS
   // A packet is only written into the result register when it is free.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_dummy) |-> status.out_free)
      else $error("packet written while result register is held");

   // A queued packet is only sent while some queue holds an entry.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (status.frame_ready || status.sample_ready))
      else $error("packet sent from empty queues");

   // The dummy packet belongs to an end-of-stream item only.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_dummy |-> status.drain)
      else $error("dummy packet outside end of stream");

   // After an input transfer the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on consecutive cycles");
`endif

endmodule

`default_nettype wire
